@@ hdl/ble_pkg.sv @@
// ----------------------------------------------------------------------------
// ble_pkg: shared definitions for the bounded list engine
// Request and result codes, field widths and the default list capacity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ble_pkg;

  // field widths
  localparam int DATA_W = 32;
  localparam int REQ_W  = 3;
  localparam int KIND_W = 3;

  // default number of list slots
  localparam int CAPACITY_DEF = 32;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_REMOVE    = 3'd2,
    REQ_COUNT     = 3'd3,
    REQ_LIST      = 3'd4
  } req_e;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ELEM     = 3'd0,
    KIND_COUNT    = 3'd1,
    KIND_NOTFOUND = 3'd2,
    KIND_END      = 3'd3,
    KIND_FULL     = 3'd4
  } kind_e;

endpackage

`default_nettype wire

@@ hdl/ble_ram.sv @@
// ----------------------------------------------------------------------------
// ble_ram: element store of the bounded list engine
// Simple dual-port memory, one write and one read port, registered read
// data that updates only on a read enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ble_ram #(
  parameter int DEPTH  = ble_pkg::CAPACITY_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [ADDR_W-1:0]          waddr_i,
  input  wire logic [ble_pkg::DATA_W-1:0] wdata_i,
  input  wire logic                       re_i,
  input  wire logic [ADDR_W-1:0]          raddr_i,
  output logic      [ble_pkg::DATA_W-1:0] rdata_o
);
  import ble_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hdl/bounded_list_engine.sv @@
// ----------------------------------------------------------------------------
// bounded_list_engine: ordered list of signed 32-bit values
// Insert front/back, remove first match, count and list, over a ring of
// slots held in one synchronous memory.
// ----------------------------------------------------------------------------
// The engine takes one request at a time. Inserts write the memory in the
// cycle they are taken; a count or a full flag passes through the pending
// register and then the output register. A remove reads the memory one slot
// per cycle from the front until it finds the value, then closes the gap
// with one read and one write per cycle. A listing sends one word per cycle
// while the sink keeps tready high, then the end marker. The single memory
// read port is walked in order. The last result may wait in the output
// register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none

module bounded_list_engine #(
  parameter int CAPACITY = ble_pkg::CAPACITY_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // request stream
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [ble_pkg::DATA_W-1:0] s_axis_tdata,  // [31:0] value
  input  wire logic [ble_pkg::REQ_W-1:0]  s_axis_tuser,  // [2:0] req_type
  // result stream
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic      [ble_pkg::DATA_W-1:0] m_axis_tdata,  // [31:0] out_data
  output logic      [ble_pkg::KIND_W-1:0] m_axis_tuser,  // [2:0] out_kind
  output logic                            m_axis_tlast   // last
);
  import ble_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(CAPACITY);
  localparam logic [CNT_W:0]   CAP_SUM   = (CNT_W + 1)'(CAPACITY);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_LIST,
    ST_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  front_q, front_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  cur_slot_q, cur_slot_d;
  logic [IDX_W-1:0]  rd_slot_q, rd_slot_d;
  logic [DATA_W-1:0] val_q, val_d;
  kind_e             pend_kind_q, pend_kind_d;
  logic [DATA_W-1:0] pend_data_q, pend_data_d;
  logic              out_valid_q, out_valid_d;
  kind_e             out_kind_q, out_kind_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic              out_last_q, out_last_d;

  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  logic              in_acc, out_free, full, shift_more;
  logic [CNT_W-1:0]  idx_next;
  logic [IDX_W-1:0]  front_dec, back_slot;
  logic [CNT_W:0]    back_sum;

  // element store
  ble_ram #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // ring slot arithmetic
  function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
    slot_inc = (s == LAST_SLOT) ? '0 : s + IDX_W'(1);
  endfunction

  assign front_dec = (front_q == '0) ? LAST_SLOT : front_q - IDX_W'(1);
  assign back_sum  = (CNT_W + 1)'(front_q) + (CNT_W + 1)'(count_q);
  assign back_slot = (back_sum >= CAP_SUM) ? IDX_W'(back_sum - CAP_SUM) : IDX_W'(back_sum);

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign out_free   = !out_valid_q || m_axis_tready;
  assign full       = (count_q == CAP_CNT);
  assign idx_next   = idx_q + CNT_W'(1);
  assign shift_more = (idx_next < count_q);

  // next-state and datapath control
  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    idx_d       = idx_q;
    cur_slot_d  = cur_slot_q;
    rd_slot_d   = rd_slot_q;
    val_d       = val_q;
    pend_kind_d = pend_kind_q;
    pend_data_d = pend_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_waddr   = cur_slot_q;
    mem_wdata   = s_axis_tdata;
    mem_re      = 1'b0;
    mem_raddr   = rd_slot_q;
    s_axis_tready = 1'b0;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        mem_raddr     = front_q;
        if (in_acc) begin
          val_d = s_axis_tdata;
          case (req_e'(s_axis_tuser))
            REQ_INS_FRONT: begin
              if (full) begin
                pend_kind_d = KIND_FULL;
                pend_data_d = '0;
                state_d     = ST_EMIT;
              end else begin
                front_d   = front_dec;
                mem_we    = 1'b1;
                mem_waddr = front_dec;
                count_d   = count_q + CNT_W'(1);
              end
            end
            REQ_INS_BACK: begin
              if (full) begin
                pend_kind_d = KIND_FULL;
                pend_data_d = '0;
                state_d     = ST_EMIT;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = back_slot;
                count_d   = count_q + CNT_W'(1);
              end
            end
            REQ_REMOVE: begin
              if (count_q == '0) begin
                pend_kind_d = KIND_NOTFOUND;
                pend_data_d = '0;
                state_d     = ST_EMIT;
              end else begin
                mem_re     = 1'b1;
                idx_d      = '0;
                cur_slot_d = front_q;
                rd_slot_d  = slot_inc(front_q);
                state_d    = ST_SEARCH;
              end
            end
            REQ_COUNT: begin
              pend_kind_d = KIND_COUNT;
              pend_data_d = DATA_W'(count_q);
              state_d     = ST_EMIT;
            end
            REQ_LIST: begin
              if (count_q == '0) begin
                pend_kind_d = KIND_END;
                pend_data_d = '0;
                state_d     = ST_EMIT;
              end else begin
                mem_re    = 1'b1;
                idx_d     = '0;
                rd_slot_d = slot_inc(front_q);
                state_d   = ST_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // compare one slot per cycle while the next one is read
      ST_SEARCH: begin
        mem_re = 1'b1;
        if (mem_rdata == val_q) begin
          rd_slot_d = slot_inc(rd_slot_q);
          state_d   = ST_SHIFT;
        end else if (!shift_more) begin
          pend_kind_d = KIND_NOTFOUND;
          pend_data_d = '0;
          state_d     = ST_EMIT;
        end else begin
          idx_d      = idx_next;
          cur_slot_d = slot_inc(cur_slot_q);
          rd_slot_d  = slot_inc(rd_slot_q);
        end
      end

      // move each later element one slot toward the front
      ST_SHIFT: begin
        if (shift_more) begin
          mem_we     = 1'b1;
          mem_waddr  = cur_slot_q;
          mem_wdata  = mem_rdata;
          mem_re     = 1'b1;
          idx_d      = idx_next;
          cur_slot_d = slot_inc(cur_slot_q);
          rd_slot_d  = slot_inc(rd_slot_q);
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = ST_IDLE;
        end
      end

      // stream elements, read data held while the sink stalls
      ST_LIST: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_ELEM;
          out_data_d  = mem_rdata;
          out_last_d  = 1'b0;
          if (!shift_more) begin
            pend_kind_d = KIND_END;
            pend_data_d = '0;
            state_d     = ST_EMIT;
          end else begin
            mem_re    = 1'b1;
            idx_d     = idx_next;
            rd_slot_d = slot_inc(rd_slot_q);
          end
        end
      end

      // closing word of a request
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = pend_kind_q;
          out_data_d  = pend_data_q;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      cur_slot_q  <= '0;
      rd_slot_q   <= '0;
      val_q       <= '0;
      pend_kind_q <= KIND_END;
      pend_data_q <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_ELEM;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      cur_slot_q  <= cur_slot_d;
      rd_slot_q   <= rd_slot_d;
      val_q       <= val_d;
      pend_kind_q <= pend_kind_d;
      pend_data_q <= pend_data_d;
      out_valid_q <= out_valid_d;
      out_kind_q  <= out_kind_d;
      out_data_q  <= out_data_d;
      out_last_q  <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // element count stays within capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("element count above capacity");

  // front position stays inside the ring
  a_front_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q <= LAST_SLOT)
    else $error("front position outside ring");

  // an accepted insert into a list with room adds exactly one element
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !full &&
     (s_axis_tuser == REQ_INS_FRONT || s_axis_tuser == REQ_INS_BACK))
    |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow the list");

  // finishing a compaction removes exactly one element
  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT && !shift_more)
    |=> count_q == $past(count_q) - CNT_W'(1) && state_q == ST_IDLE)
    else $error("remove did not shrink the list");
`endif

endmodule

`default_nettype wire
